// ----- rtl/core/sfrc_pkg.sv -----
package sfrc_pkg;

	// default payload limit; a frame stores at most this plus header and checksum
	localparam int unsigned MAX_PAYLOAD_DEF = 256;
	// type byte, two length bytes, checksum byte
	localparam int unsigned FRAME_OVERHEAD = 4;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_START_CODE     = 3'd0,
		REG_END_CODE       = 3'd1,
		REG_ESCAPE_CODE    = 3'd2,
		REG_SUB_FOR_START  = 3'd3,
		REG_SUB_FOR_END    = 3'd4,
		REG_SUB_FOR_ESCAPE = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		VERDICT_GOOD      = 3'd0,
		VERDICT_SHORT     = 3'd1,
		VERDICT_LEN_ERR   = 3'd2,
		VERDICT_CSUM_ERR  = 3'd3,
		VERDICT_ESC_ABORT = 3'd4
	} verdict_t;

	typedef enum logic {
		KIND_DATA    = 1'b0,
		KIND_VERDICT = 1'b1
	} out_kind_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] end_code;
		logic [7:0] escape_code;
		logic [7:0] sub_for_start;
		logic [7:0] sub_for_end;
		logic [7:0] sub_for_escape;
	} codes_t;

	typedef struct packed {
		out_kind_t  out_kind;
		logic [7:0] data_byte;
		logic [8:0] byte_index;
		verdict_t   verdict;
		logic [7:0] frame_type;
		logic [15:0] frame_len;
	} result_t;

endpackage

// ----- rtl/core/sfrc_in_if.sv -----
interface sfrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sfrc_out_if.sv -----
interface sfrc_out_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [7:0]  data_byte;
	logic [8:0]  byte_index;
	logic [2:0]  verdict;
	logic [7:0]  frame_type;
	logic [15:0] frame_len;

	modport source (
		output valid, output out_kind, output data_byte, output byte_index,
		output verdict, output frame_type, output frame_len, input ready
	);
	modport sink (
		input valid, input out_kind, input data_byte, input byte_index,
		input verdict, input frame_type, input frame_len, output ready
	);
endinterface

// ----- rtl/core/sfrc_cfg_regs.sv -----
module sfrc_cfg_regs
	import sfrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output codes_t     codes
);

	codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.start_code     <= 8'd126;
			codes_q.end_code       <= 8'd127;
			codes_q.escape_code    <= 8'd125;
			codes_q.sub_for_start  <= 8'd94;
			codes_q.sub_for_end    <= 8'd95;
			codes_q.sub_for_escape <= 8'd93;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_CODE:     codes_q.start_code     <= cfg_wdata;
				REG_END_CODE:       codes_q.end_code       <= cfg_wdata;
				REG_ESCAPE_CODE:    codes_q.escape_code    <= cfg_wdata;
				REG_SUB_FOR_START:  codes_q.sub_for_start  <= cfg_wdata;
				REG_SUB_FOR_END:    codes_q.sub_for_end    <= cfg_wdata;
				REG_SUB_FOR_ESCAPE: codes_q.sub_for_escape <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign codes = codes_q;

endmodule

// ----- rtl/core/sfrc_frame_core.sv -----
module sfrc_frame_core
	import sfrc_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       in_ready,
	input  codes_t     codes,
	input  logic       out_free,
	output logic       load,
	output result_t    result
);

	localparam int unsigned FRAME_MAX = MAX_PAYLOAD + FRAME_OVERHEAD;
	localparam int unsigned CNT_W     = $clog2(FRAME_MAX + 1);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FRAME_MAX);

	// input stage
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// frame state
	logic             in_frame_q, in_escape_q;
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       running_sum_q, last_byte_q, type_byte_q;
	logic [15:0]      length_field_q;

	logic             in_frame_n, in_escape_n;
	logic [CNT_W-1:0] byte_count_n;
	logic [7:0]       running_sum_n, last_byte_n, type_byte_n;
	logic [15:0]      length_field_n;

	logic        emit, try_store, advance;
	logic [7:0]  store_val;
	logic [15:0] cnt16;
	verdict_t    end_verdict;
	result_t     res;

	assign cnt16 = 16'(byte_count_q);

	always_comb begin
		if (cnt16 < 16'(FRAME_OVERHEAD))
			end_verdict = VERDICT_SHORT;
		else if (length_field_q != cnt16 - 16'(FRAME_OVERHEAD))
			end_verdict = VERDICT_LEN_ERR;
		else if (8'(running_sum_q - last_byte_q) != last_byte_q)
			end_verdict = VERDICT_CSUM_ERR;
		else
			end_verdict = VERDICT_GOOD;
	end

	always_comb begin
		in_frame_n     = in_frame_q;
		in_escape_n    = in_escape_q;
		byte_count_n   = byte_count_q;
		running_sum_n  = running_sum_q;
		last_byte_n    = last_byte_q;
		type_byte_n    = type_byte_q;
		length_field_n = length_field_q;
		emit           = 1'b0;
		try_store      = 1'b0;
		store_val      = rx_byte_s1;
		res            = '0;

		if (in_escape_q) begin
			in_escape_n = 1'b0;
			if (rx_byte_s1 == codes.sub_for_start) begin
				try_store = 1'b1;
				store_val = codes.start_code;
			end else if (rx_byte_s1 == codes.sub_for_end) begin
				try_store = 1'b1;
				store_val = codes.end_code;
			end else if (rx_byte_s1 == codes.sub_for_escape) begin
				try_store = 1'b1;
				store_val = codes.escape_code;
			end else if (in_frame_q) begin
				in_frame_n  = 1'b0;
				emit        = 1'b1;
				res.out_kind   = KIND_VERDICT;
				res.verdict    = VERDICT_ESC_ABORT;
				res.frame_type = type_byte_q;
				res.frame_len  = length_field_q;
			end
		end else if (rx_byte_s1 == codes.start_code) begin
			// a start inside a frame restarts it without a verdict
			in_frame_n     = 1'b1;
			byte_count_n   = '0;
			running_sum_n  = '0;
			last_byte_n    = '0;
			type_byte_n    = '0;
			length_field_n = '0;
		end else if (rx_byte_s1 == codes.end_code) begin
			if (in_frame_q) begin
				in_frame_n  = 1'b0;
				emit        = 1'b1;
				res.out_kind   = KIND_VERDICT;
				res.verdict    = end_verdict;
				res.frame_type = type_byte_q;
				res.frame_len  = length_field_q;
			end
		end else if (rx_byte_s1 == codes.escape_code) begin
			in_escape_n = 1'b1;
		end else begin
			try_store = 1'b1;
		end

		// bytes beyond the frame limit are dropped
		if (try_store && in_frame_q && (byte_count_q < CNT_LIMIT)) begin
			if (byte_count_q == CNT_W'(0))
				type_byte_n = store_val;
			else if (byte_count_q == CNT_W'(1))
				length_field_n[15:8] = store_val;
			else if (byte_count_q == CNT_W'(2))
				length_field_n[7:0] = store_val;
			running_sum_n = 8'(running_sum_q + store_val);
			last_byte_n   = store_val;
			byte_count_n  = CNT_W'(byte_count_q + CNT_W'(1));
			emit          = 1'b1;
			res.out_kind   = KIND_DATA;
			res.data_byte  = store_val;
			res.byte_index = cnt16[8:0];
		end
	end

	assign advance  = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || advance;
	assign load     = advance && emit;
	assign result   = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			rx_byte_s1 <= in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			in_escape_q    <= 1'b0;
			byte_count_q   <= '0;
			running_sum_q  <= '0;
			last_byte_q    <= '0;
			type_byte_q    <= '0;
			length_field_q <= '0;
		end else if (advance) begin
			in_frame_q     <= in_frame_n;
			in_escape_q    <= in_escape_n;
			byte_count_q   <= byte_count_n;
			running_sum_q  <= running_sum_n;
			last_byte_q    <= last_byte_n;
			type_byte_q    <= type_byte_n;
			length_field_q <= length_field_n;
		end
	end

`ifndef SYNTHESIS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_LIMIT)
		else $error("frame byte count past limit");

	a_verdict_closes: assert property (@(posedge clk) disable iff (!arst_n)
		load && (res.out_kind == KIND_VERDICT) |=> !in_frame_q && !in_escape_q)
		else $error("frame still open after verdict");

	a_data_counts: assert property (@(posedge clk) disable iff (!arst_n)
		load && (res.out_kind == KIND_DATA)
		|=> byte_count_q == CNT_W'($past(byte_count_q) + CNT_W'(1)))
		else $error("stored byte did not advance count");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && emit && !out_free)
		else $error("input stalled without a blocked result");
`endif

endmodule

// ----- rtl/core/sfrc_out_stage.sv -----
module sfrc_out_stage
	import sfrc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    out_free,
	sfrc_out_if.source tx
);

	logic    valid_q;
	result_t result_q;

	assign out_free = !valid_q || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (tx.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			result_q <= result;
	end

	assign tx.valid      = valid_q;
	assign tx.out_kind   = result_q.out_kind;
	assign tx.data_byte  = result_q.data_byte;
	assign tx.byte_index = result_q.byte_index;
	assign tx.verdict    = result_q.verdict;
	assign tx.frame_type = result_q.frame_type;
	assign tx.frame_len  = result_q.frame_len;

endmodule

// ----- rtl/core/stuffed_frame_receiver_checker.sv -----
// Byte-stuffed frame receiver with length and additive checksum check.
//
// rx (sink): one raw link byte per transaction. A start code opens a frame,
// an end code closes it, an escape code plus a substitute code yields a
// literal code byte. tx (source): one transaction per stored frame byte
// (out_kind 0, data_byte with byte_index) or per closed frame (out_kind 1,
// verdict with frame_type and frame_len). Codes are set through the write
// port (cfg_we, cfg_index, cfg_wdata); the user must set them only while no
// transaction is in flight, which the block itself does not enforce.
//
// A byte accepted on rx lands in the input register; its result is loaded
// into the output register when that is free, and tx.valid rises with it.
// Throughput: one byte per cycle while tx does not stall; the frame state
// update is a single pass between the input and output registers.
//
// Reset: all frame state cleared, codes back to their defaults, both
// registers empty. When tx stalls, the held result and one input byte are
// kept; rx.ready drops only if the waiting byte would produce a result.
module stuffed_frame_receiver_checker
	import sfrc_pkg::*;
#(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sfrc_in_if.sink    rx,
	sfrc_out_if.source tx,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	codes_t  codes;
	result_t result;
	logic    load;
	logic    out_free;

	// code registers
	sfrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.codes     (codes)
	);

	// input register, unstuffing and frame state, verdict logic
	sfrc_frame_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_byte  (rx.rx_byte),
		.in_ready (rx.ready),
		.codes    (codes),
		.out_free (out_free),
		.load     (load),
		.result   (result)
	);

	// result register toward tx
	sfrc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.result   (result),
		.out_free (out_free),
		.tx       (tx)
	);

endmodule

// ----- verif/stuffed_frame_receiver_checker_tb.sv -----
module stuffed_frame_receiver_checker_tb;
	import sfrc_pkg::*;

	// stored bytes per frame before the receiver starts dropping
	localparam int unsigned FRAME_CAP   = MAX_PAYLOAD_DEF + FRAME_OVERHEAD;
	// settle time after the last result: input register plus output register
	localparam int unsigned SETTLE      = 4;
	// generous: every byte at its longest gap and every result at its longest stall
	localparam int unsigned CYCLE_LIMIT = 600000;

	localparam codes_t DEFAULT_CODES = '{
		start_code: 8'd126, end_code: 8'd127, escape_code: 8'd125,
		sub_for_start: 8'd94, sub_for_end: 8'd95, sub_for_escape: 8'd93
	};

	typedef logic [7:0] byte_q_t[$];

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_wdata;

	sfrc_in_if  rx_link ();
	sfrc_out_if tx_link ();

	stuffed_frame_receiver_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_link),
		.tx        (tx_link),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// Deframer model: codes as written on the register port, plus the frame
	// state the block keeps between bytes.
	// ---------------------------------------------------------------------
	codes_t      codes;
	logic        fr_open;
	logic        fr_escaped;
	int unsigned fr_count;      // stored frame bytes, saturates at FRAME_CAP
	logic [7:0]  fr_sum;        // mod-256 sum of stored bytes
	logic [7:0]  fr_last;
	logic [7:0]  fr_type;
	logic [15:0] fr_len;

	result_t     pending_results[$];   // results still owed by the block

	// bookkeeping
	int unsigned faults;
	int unsigned bytes_sent;
	int unsigned data_checked;
	int unsigned verdicts_checked;
	int unsigned verdict_tally[5];
	int unsigned code_sets;
	int unsigned cycle_count;

	// idle pacing, switched per frame so some stretches run back to back
	bit          src_idle_on;
	bit          sink_stall_on;
	int unsigned sink_hold;
	int unsigned sink_roll;

	// Frame byte goes into the store and out on tx, unless the frame is
	// closed or already full (overlong bytes are dropped with no transaction).
	function automatic void keep_byte(logic [7:0] b);
		result_t r;
		if (!fr_open || fr_count >= FRAME_CAP)
			return;
		if (fr_count == 0)
			fr_type = b;
		else if (fr_count == 1)
			fr_len[15:8] = b;
		else if (fr_count == 2)
			fr_len[7:0] = b;
		fr_sum  = fr_sum + b;
		fr_last = b;
		r = '0;
		r.out_kind   = KIND_DATA;
		r.verdict    = VERDICT_GOOD;
		r.data_byte  = b;
		r.byte_index = fr_count[8:0];
		fr_count++;
		pending_results.push_back(r);
	endfunction

	function automatic void close_frame(verdict_t v);
		result_t r;
		r = '0;
		r.out_kind   = KIND_VERDICT;
		r.verdict    = v;
		r.frame_type = fr_type;
		r.frame_len  = fr_len;
		pending_results.push_back(r);
	endfunction

	// checks in priority order: short, length field, checksum
	function automatic verdict_t judge_frame();
		logic [7:0]  body_sum;
		logic [15:0] body_len;
		body_sum = fr_sum - fr_last;
		body_len = 16'(fr_count - FRAME_OVERHEAD);
		if (fr_count < FRAME_OVERHEAD)
			return VERDICT_SHORT;
		if (fr_len != body_len)
			return VERDICT_LEN_ERR;
		if (body_sum != fr_last)
			return VERDICT_CSUM_ERR;
		return VERDICT_GOOD;
	endfunction

	// One raw link byte. Escape state wins over code matching; codes are
	// compared start, end, escape, and substitutes in the same order.
	function automatic void deframe_byte(logic [7:0] c);
		if (fr_escaped) begin
			fr_escaped = 1'b0;
			if (c == codes.sub_for_start)
				keep_byte(codes.start_code);
			else if (c == codes.sub_for_end)
				keep_byte(codes.end_code);
			else if (c == codes.sub_for_escape)
				keep_byte(codes.escape_code);
			else if (fr_open) begin
				fr_open = 1'b0;
				close_frame(VERDICT_ESC_ABORT);
			end
			return;
		end
		if (c == codes.start_code) begin
			// also a silent restart when a frame is already open
			fr_open  = 1'b1;
			fr_count = 0;
			fr_sum   = '0;
			fr_last  = '0;
			fr_type  = '0;
			fr_len   = '0;
		end else if (c == codes.end_code) begin
			if (fr_open) begin
				fr_open = 1'b0;
				close_frame(judge_frame());
			end
		end else if (c == codes.escape_code) begin
			fr_escaped = 1'b1;
		end else begin
			keep_byte(c);
		end
	endfunction

	// ---------------------------------------------------------------------
	// tx side: random backpressure, changed at the falling edge
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		sink_roll = $urandom_range(0, 99);
		if (sink_hold > 0) begin
			tx_link.ready <= 1'b0;
			sink_hold--;
		end else if (!sink_stall_on || sink_roll < 70) begin
			tx_link.ready <= 1'b1;
		end else if (sink_roll < 95) begin
			tx_link.ready <= 1'b0;
			sink_hold = $urandom_range(0, 2);
		end else begin
			tx_link.ready <= 1'b0;
			sink_hold = $urandom_range(10, 40);
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
				$time, name, want, want, got, got);
			faults++;
		end
	endfunction

	// every tx transaction is matched against the oldest owed result
	result_t head;
	always @(posedge clk) begin
		if (arst_n && tx_link.valid && tx_link.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction: kind %0d byte 0x%0h index %0d verdict %0d",
					$time, tx_link.out_kind, tx_link.data_byte, tx_link.byte_index,
					tx_link.verdict);
				faults++;
			end else begin
				head = pending_results.pop_front();
				check_field("out_kind", head.out_kind, tx_link.out_kind);
				check_field("data_byte", head.data_byte, tx_link.data_byte);
				check_field("byte_index", head.byte_index, tx_link.byte_index);
				check_field("verdict", head.verdict, tx_link.verdict);
				check_field("frame_type", head.frame_type, tx_link.frame_type);
				check_field("frame_len", head.frame_len, tx_link.frame_len);
				if (head.out_kind == KIND_VERDICT) begin
					verdicts_checked++;
					verdict_tally[head.verdict]++;
				end else begin
					data_checked++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("** stuffed_frame_receiver_checker: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!src_idle_on || roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// One rx transaction. valid stays high into the next byte when no gap is drawn,
	// so back-to-back traffic gets one assignment per edge while rx.ready is high.
	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		@(negedge clk);
		rx_link.valid   <= 1'b1;
		rx_link.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_link.ready);
		deframe_byte(b);
		bytes_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			rx_link.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// literal code bytes go out as escape plus substitute
	task automatic send_stuffed(logic [7:0] b);
		if (b == codes.start_code) begin
			send_byte(codes.escape_code);
			send_byte(codes.sub_for_start);
		end else if (b == codes.end_code) begin
			send_byte(codes.escape_code);
			send_byte(codes.sub_for_end);
		end else if (b == codes.escape_code) begin
			send_byte(codes.escape_code);
			send_byte(codes.sub_for_escape);
		end else begin
			send_byte(b);
		end
	endtask

	// type, big-endian length, payload, additive checksum, stuffed and framed
	task automatic send_frame(logic [7:0] msg, byte_q_t payload, bit bad_len, bit bad_sum);
		byte_q_t     body;
		logic [15:0] len_field;
		logic [7:0]  sum;
		len_field = 16'(payload.size());
		if (bad_len)
			len_field ^= 16'h1 << $urandom_range(0, 15);
		body.push_back(msg);
		body.push_back(len_field[15:8]);
		body.push_back(len_field[7:0]);
		foreach (payload[i])
			body.push_back(payload[i]);
		sum = '0;
		foreach (body[i])
			sum += body[i];
		if (bad_sum)
			sum ^= 8'h1 << $urandom_range(0, 7);
		body.push_back(sum);
		send_byte(codes.start_code);
		foreach (body[i])
			send_stuffed(body[i]);
		send_byte(codes.end_code);
	endtask

	// biased toward the active codes so frames keep hitting them
	function automatic logic [7:0] pick_byte(int unsigned code_pct);
		if ($urandom_range(0, 99) >= code_pct)
			return 8'($urandom);
		case ($urandom_range(0, 5))
			0:       return codes.start_code;
			1:       return codes.end_code;
			2:       return codes.escape_code;
			3:       return codes.sub_for_start;
			4:       return codes.sub_for_end;
			default: return codes.sub_for_escape;
		endcase
	endfunction

	function automatic logic [7:0] non_sub_byte();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == codes.sub_for_start || b == codes.sub_for_end ||
			b == codes.sub_for_escape);
		return b;
	endfunction

	function automatic byte_q_t random_payload(int unsigned n);
		byte_q_t p;
		repeat (n) p.push_back(pick_byte(15));
		return p;
	endfunction

	// Sender goes quiet until every owed result is back, then lets the
	// pipeline settle for bytes that produce nothing.
	task automatic wait_for_results();
		@(negedge clk);
		rx_link.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [7:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			REG_START_CODE:     codes.start_code     = v;
			REG_END_CODE:       codes.end_code       = v;
			REG_ESCAPE_CODE:    codes.escape_code    = v;
			REG_SUB_FOR_START:  codes.sub_for_start  = v;
			REG_SUB_FOR_END:    codes.sub_for_end    = v;
			REG_SUB_FOR_ESCAPE: codes.sub_for_escape = v;
			default: ;
		endcase
	endtask

	// only called with the block idle
	task automatic write_codes(codes_t c);
		write_reg(REG_START_CODE, c.start_code);
		write_reg(REG_END_CODE, c.end_code);
		write_reg(REG_ESCAPE_CODE, c.escape_code);
		write_reg(REG_SUB_FOR_START, c.sub_for_start);
		write_reg(REG_SUB_FOR_END, c.sub_for_end);
		write_reg(REG_SUB_FOR_ESCAPE, c.sub_for_escape);
		@(negedge clk);
		cfg_we <= 1'b0;
		code_sets++;
	endtask

	// Mostly well-formed frames with random content and lengths, the rest
	// broken frames and loose bytes between frames.
	task automatic random_traffic(int unsigned n_bytes);
		int unsigned stop_at;
		int unsigned roll;
		int unsigned n;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			src_idle_on   = ($urandom_range(0, 3) != 0);
			sink_stall_on = ($urandom_range(0, 3) != 0);
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
				send_frame(pick_byte(10), random_payload(n),
					$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
			end else if (roll < 85) begin
				// opened, then closed, abandoned, aborted by a bad escape, or restarted
				send_byte(codes.start_code);
				repeat ($urandom_range(0, 5)) send_stuffed(pick_byte(10));
				case ($urandom_range(0, 2))
					0: begin
						send_byte(codes.escape_code);
						send_byte(non_sub_byte());
					end
					1: send_byte(codes.end_code);
					default: ;
				endcase
			end else begin
				repeat ($urandom_range(1, 6)) send_byte(pick_byte(50));
			end
			if ($urandom_range(0, 24) == 0)
				wait_for_results();
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// good frame whose type and payload need all three escape pairs
	task automatic test_good_frame();
		byte_q_t p;
		p.push_back(codes.end_code);
		p.push_back(codes.escape_code);
		p.push_back(8'h00);
		p.push_back(8'hFF);
		send_frame(codes.start_code, p, 1'b0, 1'b0);
	endtask

	// each failing verdict at least once
	task automatic test_verdict_paths();
		byte_q_t p;
		// empty frame: short, nothing captured
		send_byte(codes.start_code);
		send_byte(codes.end_code);
		// short frame with partial header
		send_byte(codes.start_code);
		send_byte(8'hA5);
		send_byte(8'h00);
		send_byte(codes.end_code);
		p.push_back(8'h3C);
		send_frame(8'h01, p, 1'b1, 1'b0);
		p.delete();
		send_frame(8'h80, p, 1'b0, 1'b1);
		// escape followed by a non-substitute aborts the open frame
		send_byte(codes.start_code);
		send_byte(8'h11);
		send_byte(codes.escape_code);
		send_byte(non_sub_byte());
	endtask

	// loose bytes between frames, then a restart inside a frame
	task automatic test_out_of_frame();
		send_byte(codes.end_code);
		send_byte(codes.escape_code);
		send_byte(codes.sub_for_start);
		send_byte(codes.escape_code);
		send_byte(non_sub_byte());
		send_byte(8'h55);
		send_byte(codes.start_code);
		send_byte(8'h42);
		send_byte(8'h01);
		send_byte(codes.start_code);
		send_byte(8'h99);
		send_byte(codes.end_code);
	endtask

	// one payload byte past the limit: the store fills exactly, only the
	// checksum is dropped, the length check fails
	task automatic test_length_limit();
		send_frame(8'hA5, random_payload(MAX_PAYLOAD_DEF + 1), 1'b0, 1'b0);
	endtask

	task automatic test_default_codes();
		random_traffic(20);
	endtask

	// codes at both ends of the byte range, then mirrored
	task automatic test_extreme_codes();
		write_codes('{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h02, 8'hFD});
		random_traffic(15);
		wait_for_results();
		write_codes('{8'hFF, 8'h00, 8'hFE, 8'h01, 8'hFD, 8'h02});
		random_traffic(15);
	endtask

	task automatic test_random_codes();
		codes_t c;
		repeat (2) begin
			c.start_code     = 8'($urandom);
			c.end_code       = 8'($urandom);
			c.escape_code    = 8'($urandom);
			c.sub_for_start  = 8'($urandom);
			c.sub_for_end    = 8'($urandom);
			c.sub_for_escape = 8'($urandom);
			write_codes(c);
			random_traffic(12);
			wait_for_results();
		end
	endtask

	// codes drawn from a tiny set so they collide with each other and with
	// the substitutes, exercising the compare order
	task automatic test_overlapping_codes();
		codes_t c;
		c.start_code     = 8'($urandom_range(0, 3));
		c.end_code       = 8'($urandom_range(0, 3));
		c.escape_code    = 8'($urandom_range(0, 3));
		c.sub_for_start  = 8'($urandom_range(0, 3));
		c.sub_for_end    = 8'($urandom_range(0, 3));
		c.sub_for_escape = 8'($urandom_range(0, 3));
		write_codes(c);
		random_traffic(15);
		wait_for_results();
		write_codes(DEFAULT_CODES);
		random_traffic(10);
	endtask

	initial begin
		arst_n          = 1'b0;
		rx_link.valid   = 1'b0;
		rx_link.rx_byte = '0;
		cfg_we          = 1'b0;
		cfg_index       = REG_START_CODE;
		cfg_wdata       = '0;
		codes           = DEFAULT_CODES;
		fr_open         = 1'b0;
		fr_escaped      = 1'b0;
		fr_count        = 0;
		fr_sum          = '0;
		fr_last         = '0;
		fr_type         = '0;
		fr_len          = '0;
		code_sets       = 1;
		src_idle_on     = 1'b1;
		sink_stall_on   = 1'b1;
		sink_hold       = 0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// directed checks with reset codes
		test_good_frame();
		test_verdict_paths();
		test_out_of_frame();
		wait_for_results();
		test_length_limit();
		wait_for_results();

		// random traffic across several code sets
		test_default_codes();
		wait_for_results();
		test_extreme_codes();
		wait_for_results();
		test_random_codes();
		test_overlapping_codes();
		wait_for_results();

		$display("Sent %0d link bytes under %0d code sets; checked %0d frame bytes, %0d verdicts.",
			bytes_sent, code_sets, data_checked, verdicts_checked);
		$display("Verdicts: good %0d, short %0d, length %0d, checksum %0d, abort %0d.",
			verdict_tally[VERDICT_GOOD], verdict_tally[VERDICT_SHORT],
			verdict_tally[VERDICT_LEN_ERR], verdict_tally[VERDICT_CSUM_ERR],
			verdict_tally[VERDICT_ESC_ABORT]);
		if (pending_results.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
		if (faults == 0 && pending_results.size() == 0)
			$display("** stuffed_frame_receiver_checker: PASSED **");
		else
			$display("** stuffed_frame_receiver_checker: FAILED **");
		$finish;
	end

endmodule

// ----- stuffed_frame_receiver_checker.f -----
rtl/core/sfrc_pkg.sv
rtl/core/sfrc_in_if.sv
rtl/core/sfrc_out_if.sv
rtl/core/sfrc_cfg_regs.sv
rtl/core/sfrc_frame_core.sv
rtl/core/sfrc_out_stage.sv
rtl/core/stuffed_frame_receiver_checker.sv
verif/stuffed_frame_receiver_checker_tb.sv
